// ===== sv/pomr_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types and constants for the per-object window mean block
package pomr_pkg;

  localparam int FIELD_W    = 12;
  localparam int SLOT_W     = 6;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int NUM_FIELDS = 4;
  localparam int MAX_SLOTS  = 1 << SLOT_W;

  typedef logic [FIELD_W-1:0] field_t;
  // index 0 x, 1 y, 2 width, 3 height
  typedef field_t [NUM_FIELDS-1:0] rect_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NOP    = 2'd3
  } command_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_ADDED   = 2'd0,
    STAT_UPDATED = 2'd1,
    STAT_REMOVED = 2'd2,
    STAT_ERROR   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_READ,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } state_t;

endpackage

// ===== sv/pomr_serial_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider, four lanes sharing one divisor
module pomr_serial_div import pomr_pkg::*; #(
  parameter int SUM_W = 16,
  parameter int CNT_W = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [NUM_FIELDS-1:0][SUM_W-1:0]    dividend,
  input  logic [CNT_W-1:0]                    divisor,
  output logic                                done,
  output rect_t                               quotient
);

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic                             busy, busy_next;
  logic                             done_next;
  logic [STEP_W-1:0]                step, step_next;
  logic [CNT_W-1:0]                 dvs;
  logic [NUM_FIELDS-1:0][SUM_W-1:0] quo, quo_next;
  logic [NUM_FIELDS-1:0][CNT_W-1:0] rem, rem_next;
  logic [NUM_FIELDS-1:0][CNT_W:0]   trial;

  always_comb begin
    busy_next = busy;
    step_next = step;
    done_next = 1'b0;
    quo_next  = quo;
    rem_next  = rem;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      trial[f] = {rem[f], quo[f][SUM_W-1]};
    end
    if (start) begin
      busy_next = 1'b1;
      step_next = '0;
      quo_next  = dividend;
      rem_next  = '0;
    end else if (busy) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
        if (trial[f] >= {1'b0, dvs}) begin
          rem_next[f] = CNT_W'(trial[f] - {1'b0, dvs});
          quo_next[f] = {quo[f][SUM_W-2:0], 1'b1};
        end else begin
          rem_next[f] = trial[f][CNT_W-1:0];
          quo_next[f] = {quo[f][SUM_W-2:0], 1'b0};
        end
      end
      if (step == STEP_W'(SUM_W - 1)) begin
        busy_next = 1'b0;
        done_next = 1'b1;
      end else begin
        step_next = step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= busy_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    step <= step_next;
    quo  <= quo_next;
    rem  <= rem_next;
    if (start) begin
      dvs <= divisor;
    end
  end

  always_comb begin
    for (int f = 0; f < NUM_FIELDS; f++) begin
      quotient[f] = quo[f][FIELD_W-1:0];
    end
  end

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("divider done without a run");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem[0] < dvs))
    else $error("partial remainder not below divisor");

endmodule

// ===== sv/per_object_window_mean_rect.sv =====
`timescale 1ns / 1ps
// Top level: per-object sliding window of rectangles with windowed mean
//
// Command channel: cmd_valid / cmd_stall with command, object_slot and the
// rectangle fields; a transaction completes when cmd_valid is high and
// cmd_stall low. Result channel: res_valid / res_stall with result_slot,
// status and the four means; one result per transaction, none for the
// no-op command code.
// One command is processed at a time; cmd_stall is high from acceptance
// until the result is loaded into the output register.
// Add, delete and errors go from acceptance through S_LOOKUP to S_OUT.
// An update reads the window store once per entry on its single read port
// (count = stored entries, up to WINDOW), then the bit-serial divider
// produces one quotient bit per cycle (SUM_W = 12 + clog2(WINDOW) bits).
// Reset frees every slot and empties the output register; no clearing
// pass is needed. While res_stall holds a result, the next command is
// still taken and worked on until its own result is ready to load.
module per_object_window_mean_rect_core import pomr_pkg::*; #(
  parameter int WINDOW      = 10,
  parameter int NUM_OBJECTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [SLOT_W-1:0]  object_slot,
  input  logic [FIELD_W-1:0] rect_x,
  input  logic [FIELD_W-1:0] rect_y,
  input  logic [FIELD_W-1:0] rect_width,
  input  logic [FIELD_W-1:0] rect_height,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [SLOT_W-1:0]  result_slot,
  output logic [STAT_W-1:0]  status,
  output logic [FIELD_W-1:0] mean_x,
  output logic [FIELD_W-1:0] mean_y,
  output logic [FIELD_W-1:0] mean_width,
  output logic [FIELD_W-1:0] mean_height
);

  localparam int SLOTS      = (NUM_OBJECTS < MAX_SLOTS) ? NUM_OBJECTS : MAX_SLOTS;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH      = SLOTS * WINDOW;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int POS_W      = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int SUM_W      = FIELD_W + $clog2(WINDOW);
  localparam int RING_DEPTH = 1 << IDX_W;

  state_t                           state, state_next;
  command_t                         cur_cmd, cur_cmd_next;
  logic [SLOT_W-1:0]                cur_slot, cur_slot_next;
  logic [IDX_W-1:0]                 cur_idx;
  rect_t                            cur_rect, cur_rect_next;
  logic                             cur_ok, cur_ok_next;
  logic [ADDR_W-1:0]                base, base_next;
  logic [CNT_W-1:0]                 count, count_next;
  logic [CNT_W-1:0]                 rd_idx, rd_idx_next;
  logic                             pend, pend_next;
  logic [NUM_FIELDS-1:0][SUM_W-1:0] acc, acc_next;
  logic [SLOTS-1:0]                 in_use, in_use_next;
  rect_t                            res_mean, res_mean_next;
  status_t                          res_stat, res_stat_next;
  logic                             res_valid_next;
  logic [SLOT_W-1:0]                result_slot_next;
  logic [STAT_W-1:0]                status_next;
  rect_t                            mean_next;

  rect_t                            store_mem [DEPTH];
  rect_t                            store_rd;
  logic                             store_we;
  logic [ADDR_W-1:0]                store_waddr;
  logic [ADDR_W-1:0]                store_raddr;

  logic [POS_W:0]                   ring_mem [RING_DEPTH];
  logic [POS_W:0]                   ring_rd;
  logic                             ring_we;
  logic [POS_W:0]                   ring_wdata;
  logic [POS_W-1:0]                 pos;
  logic                             full;
  logic [CNT_W-1:0]                 pos_inc;

  logic                             div_start;
  logic                             div_done;
  rect_t                            quotient;

  assign cmd_stall   = (state != S_IDLE);
  assign cur_idx     = cur_slot[IDX_W-1:0];
  assign store_raddr = base + ADDR_W'(rd_idx);

  pomr_serial_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next       = state;
    cur_cmd_next     = cur_cmd;
    cur_slot_next    = cur_slot;
    cur_rect_next    = cur_rect;
    cur_ok_next      = cur_ok;
    base_next        = base;
    count_next       = count;
    rd_idx_next      = rd_idx;
    pend_next        = 1'b0;
    acc_next         = acc;
    in_use_next      = in_use;
    res_mean_next    = res_mean;
    res_stat_next    = res_stat;
    res_valid_next   = res_valid && res_stall;
    result_slot_next = result_slot;
    status_next      = status;
    mean_next        = {mean_height, mean_width, mean_y, mean_x};
    store_we         = 1'b0;
    store_waddr      = base;
    ring_we          = 1'b0;
    ring_wdata       = '0;
    div_start        = 1'b0;

    pos  = ring_rd[POS_W-1:0];
    full = ring_rd[POS_W];
    if (int'(pos) >= WINDOW) begin
      pos = '0;
    end
    pos_inc = CNT_W'(pos) + 1'b1;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cur_cmd_next  = command_t'(command);
          cur_slot_next = object_slot;
          cur_rect_next = {rect_height, rect_width, rect_y, rect_x};
          cur_ok_next   = (int'(object_slot) < NUM_OBJECTS);
          base_next     = ADDR_W'(int'(object_slot[IDX_W-1:0]) * WINDOW);
          if (command_t'(command) != CMD_NOP) begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        state_next    = S_OUT;
        res_mean_next = '0;
        res_stat_next = STAT_ERROR;
        if (cur_ok) begin
          case (cur_cmd)
            CMD_ADD: begin
              store_we             = 1'b1;
              ring_we              = 1'b1;
              ring_wdata           = {1'b0, POS_W'(1)};
              in_use_next[cur_idx] = 1'b1;
              res_stat_next        = STAT_ADDED;
              res_mean_next        = cur_rect;
            end
            CMD_DELETE: begin
              in_use_next[cur_idx] = 1'b0;
              res_stat_next        = STAT_REMOVED;
            end
            CMD_UPDATE: begin
              if (in_use[cur_idx]) begin
                store_we      = 1'b1;
                store_waddr   = base + ADDR_W'(pos);
                count_next    = full ? CNT_W'(WINDOW) : pos_inc;
                ring_we       = 1'b1;
                if (pos_inc == CNT_W'(WINDOW)) begin
                  ring_wdata = {1'b1, {POS_W{1'b0}}};
                end else begin
                  ring_wdata = {full, pos_inc[POS_W-1:0]};
                end
                rd_idx_next   = '0;
                acc_next      = '0;
                res_stat_next = STAT_UPDATED;
                state_next    = S_READ;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        if (pend) begin
          for (int f = 0; f < NUM_FIELDS; f++) begin
            acc_next[f] = acc[f] + SUM_W'(store_rd[f]);
          end
        end
        if (rd_idx == count) begin
          state_next = S_DIV_START;
        end else begin
          rd_idx_next = rd_idx + 1'b1;
          pend_next   = 1'b1;
        end
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          res_mean_next = quotient;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_valid || !res_stall) begin
          res_valid_next   = 1'b1;
          result_slot_next = cur_slot;
          status_next      = res_stat;
          mean_next        = res_mean;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      in_use    <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      in_use    <= in_use_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_cmd     <= cur_cmd_next;
    cur_slot    <= cur_slot_next;
    cur_rect    <= cur_rect_next;
    cur_ok      <= cur_ok_next;
    base        <= base_next;
    count       <= count_next;
    rd_idx      <= rd_idx_next;
    acc         <= acc_next;
    res_mean    <= res_mean_next;
    res_stat    <= res_stat_next;
    result_slot <= result_slot_next;
    status      <= status_next;
    mean_x      <= mean_next[0];
    mean_y      <= mean_next[1];
    mean_width  <= mean_next[2];
    mean_height <= mean_next[3];
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= cur_rect;
    end
    store_rd <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[cur_idx] <= ring_wdata;
    end
    ring_rd <= ring_mem[object_slot[IDX_W-1:0]];
  end

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ((rd_idx <= count) && (count != '0)))
    else $error("window read index beyond entry count");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_OUT))
    else $error("result raised outside output state");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(result_slot) && $stable(status)
      && $stable(mean_x) && $stable(mean_y) && $stable(mean_width)
      && $stable(mean_height)))
    else $error("stalled result changed");

endmodule

// ===== tb/tb_per_object_window_mean_rect_core.sv =====
`timescale 1ns / 1ps
// Testbench: self-checking random and directed test of the per-object window mean core
module tb_per_object_window_mean_rect_core import pomr_pkg::*;;

  localparam int WINDOW      = 10;
  localparam int NUM_OBJ     = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 64;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    status_t           stat;
    rect_t             mean;
  } window_result_t;

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  logic [CMD_W-1:0]   command;
  logic [SLOT_W-1:0]  object_slot;
  logic [FIELD_W-1:0] rect_x;
  logic [FIELD_W-1:0] rect_y;
  logic [FIELD_W-1:0] rect_width;
  logic [FIELD_W-1:0] rect_height;
  logic               res_valid;
  logic               res_stall;
  logic [SLOT_W-1:0]  result_slot;
  logic [STAT_W-1:0]  status;
  logic [FIELD_W-1:0] mean_x;
  logic [FIELD_W-1:0] mean_y;
  logic [FIELD_W-1:0] mean_width;
  logic [FIELD_W-1:0] mean_height;

  per_object_window_mean_rect_core #(
    .WINDOW(WINDOW),
    .NUM_OBJECTS(NUM_OBJ)
  ) dut (.*);

  // predictor state
  rect_t       hist [NUM_OBJ][WINDOW];
  int unsigned ring_pos [NUM_OBJ];
  bit          wrapped [NUM_OBJ];
  bit          live [NUM_OBJ];

  window_result_t expected_results[$];

  string field_name [NUM_FIELDS] = '{"x", "y", "width", "height"};

  bit tx_idle;
  bit rx_idle;
  int stall_left;
  int hold_left;
  int errors;
  int n_add, n_upd, n_del, n_nop, n_err, n_full, n_checked;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rect_t mk_rect(field_t x, field_t y, field_t w, field_t h);
    return {h, w, y, x};
  endfunction

  function automatic field_t rand_field();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return field_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic rect_t rand_rect();
    return mk_rect(rand_field(), rand_field(), rand_field(), rand_field());
  endfunction

  function automatic bit find_live_slot(output logic [SLOT_W-1:0] s);
    int start;
    start = $urandom_range(0, NUM_OBJ - 1);
    s = SLOT_W'(start);
    for (int k = 0; k < NUM_OBJ; k++)
      if (live[(start + k) % NUM_OBJ]) begin
        s = SLOT_W'((start + k) % NUM_OBJ);
        return 1'b1;
      end
    return 1'b0;
  endfunction

  // windowed mean per slot; returns 0 when the command yields no result
  function automatic bit predict_window_mean(command_t c, logic [SLOT_W-1:0] s, rect_t r,
                                             output window_result_t e);
    int unsigned field_sum [NUM_FIELDS];
    int unsigned pos;
    int unsigned cnt;
    e.slot = s;
    e.stat = STAT_ERROR;
    e.mean = '0;
    if (c == CMD_NOP) return 1'b0;
    if (s >= NUM_OBJ) return 1'b1;
    case (c)
      CMD_ADD: begin
        hist[s][0] = r;
        ring_pos[s] = 1;
        wrapped[s] = 1'b0;
        live[s] = 1'b1;
        e.stat = STAT_ADDED;
        e.mean = r;
      end
      CMD_DELETE: begin
        live[s] = 1'b0;
        e.stat = STAT_REMOVED;
      end
      default: begin
        if (live[s]) begin
          pos = ring_pos[s];
          if (pos >= WINDOW) pos = 0;
          hist[s][pos] = r;
          cnt = wrapped[s] ? WINDOW : pos + 1;
          if (cnt == WINDOW) n_full++;
          for (int f = 0; f < NUM_FIELDS; f++) begin
            field_sum[f] = 0;
            for (int i = 0; i < cnt; i++) field_sum[f] += hist[s][i][f];
            e.mean[f] = FIELD_W'(field_sum[f] / cnt);
          end
          pos++;
          if (pos >= WINDOW) begin
            pos = 0;
            wrapped[s] = 1'b1;
          end
          ring_pos[s] = pos;
          e.stat = STAT_UPDATED;
        end
      end
    endcase
    return 1'b1;
  endfunction

  task automatic send_cmd(command_t c, logic [SLOT_W-1:0] s, rect_t r);
    window_result_t e;
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid   <= 1'b1;
    command     <= c;
    object_slot <= s;
    rect_x      <= r[0];
    rect_y      <= r[1];
    rect_width  <= r[2];
    rect_height <= r[3];
    do @(posedge clk); while (cmd_stall);
    case (c)
      CMD_ADD:    n_add++;
      CMD_UPDATE: n_upd++;
      CMD_DELETE: n_del++;
      default:    n_nop++;
    endcase
    if (predict_window_mean(c, s, r, e)) begin
      if (e.stat == STAT_ERROR) n_err++;
      expected_results.push_back(e);
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_add_extremes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_cmd(CMD_ADD, 6'd0, {NUM_FIELDS{12'hFFF}});
    send_cmd(CMD_ADD, 6'd63, '0);
    send_cmd(CMD_ADD, 6'd42, mk_rect(12'hAAA, 12'h555, 12'hFFF, 12'h000));
  endtask

  task automatic test_update_mean();
    send_cmd(CMD_UPDATE, 6'd0, '0);
    send_cmd(CMD_UPDATE, 6'd63, {NUM_FIELDS{12'hFFF}});
    send_cmd(CMD_UPDATE, 6'd42, mk_rect(12'd1, 12'd2, 12'd3, 12'd4));
  endtask

  // slot 0 holds two entries; ten more run the ring past its end
  task automatic test_window_wrap();
    repeat (10) send_cmd(CMD_UPDATE, 6'd0, rand_rect());
  endtask

  task automatic test_free_slot();
    send_cmd(CMD_UPDATE, 6'd5, rand_rect());
    send_cmd(CMD_DELETE, 6'd7, rand_rect());
  endtask

  task automatic test_delete_readd();
    send_cmd(CMD_DELETE, 6'd63, rand_rect());
    send_cmd(CMD_UPDATE, 6'd63, rand_rect());
    send_cmd(CMD_ADD, 6'd63, rand_rect());
    send_cmd(CMD_UPDATE, 6'd63, rand_rect());
  endtask

  task automatic test_nop();
    send_cmd(CMD_NOP, 6'd0, rand_rect());
    send_cmd(CMD_NOP, 6'd63, {NUM_FIELDS{12'hFFF}});
    send_cmd(CMD_UPDATE, 6'd0, rand_rect());
  endtask

  // output held for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    hold_left = 300;
    send_cmd(CMD_ADD, 6'd42, rand_rect());
    repeat (5) send_cmd(CMD_UPDATE, 6'd42, rand_rect());
    wait_all_results();
  endtask

  task automatic test_random_traffic(int n, bit tx_on, bit rx_on);
    command_t c;
    logic [SLOT_W-1:0] s;
    int pick;
    int sent;
    tx_idle = tx_on;
    rx_idle = rx_on;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      s = SLOT_W'($urandom_range(0, NUM_OBJ - 1));
      if (pick < 76) c = find_live_slot(s) ? CMD_UPDATE : CMD_ADD;
      else if (pick < 81) c = CMD_ADD;
      else if (pick < 86) begin
        c = CMD_DELETE;
        void'(find_live_slot(s));
      end
      else if (pick < 90) c = CMD_DELETE;
      else if (pick < 96) c = CMD_UPDATE;
      else c = CMD_NOP;
      send_cmd(c, s, rand_rect());
      if (c != CMD_NOP) sent++;
    end
  endtask

  // receiver: per-transaction stall, plus the long hold when requested
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    window_result_t want;
    rect_t got;
    if (!rst && res_valid && !res_stall) begin
      got = {mean_height, mean_width, mean_y, mean_x};
      stall_left = rx_idle ? $urandom_range(0, 19) : 0;
      n_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, slot %0d status %0d", $time, result_slot, status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result_slot !== want.slot) begin
          $display("%0t: result_slot expected %0d, actual %0d", $time, want.slot, result_slot);
          errors++;
        end
        if (status !== want.stat) begin
          $display("%0t: slot %0d status expected %0d, actual %0d",
                   $time, want.slot, want.stat, status);
          errors++;
        end
        for (int f = 0; f < NUM_FIELDS; f++)
          if (got[f] !== want.mean[f]) begin
            $display("%0t: slot %0d mean %s expected %0d, actual %0d",
                     $time, want.slot, field_name[f], want.mean[f], got[f]);
            errors++;
          end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    cmd_valid   = 1'b0;
    command     = CMD_NOP;
    object_slot = '0;
    rect_x      = '0;
    rect_y      = '0;
    rect_width  = '0;
    rect_height = '0;
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    stall_left  = 0;
    hold_left   = 0;
    errors      = 0;
    n_add = 0; n_upd = 0; n_del = 0; n_nop = 0; n_err = 0; n_full = 0; n_checked = 0;
    for (int i = 0; i < NUM_OBJ; i++) begin
      ring_pos[i] = 0;
      wrapped[i]  = 1'b0;
      live[i]     = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_add_extremes();
    test_update_mean();
    test_window_wrap();
    test_free_slot();
    test_delete_readd();
    test_nop();
    test_output_backpressure();
    test_random_traffic(165, 1'b0, 1'b0);
    wait_all_results();
    test_random_traffic(185, 1'b1, 1'b0);
    test_random_traffic(165, 1'b0, 1'b1);
    wait_all_results();
    test_random_traffic(175, 1'b1, 1'b1);
    wait_all_results();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d add, %0d update, %0d delete and %0d no-op transactions; %0d results",
             n_add, n_upd, n_del, n_nop, n_checked);
    $display("%0d updates averaged a full window, %0d error results, %0d mismatches",
             n_full, n_err, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== per_object_window_mean_rect_core.f =====
sv/pomr_pkg.sv
sv/pomr_serial_div.sv
sv/per_object_window_mean_rect.sv
tb/tb_per_object_window_mean_rect_core.sv
